// ----- rtl/prld_pkg.sv -----
// shared types and constants of the palette run-length decoder
package prld_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 1024;
    localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam int COLOR_BITS    = 16;

    // token layout
    localparam int COUNT_BITS      = 3;
    localparam int INDEX_PART_BITS = 5;
    localparam int INDEX_BITS      = 2 * INDEX_PART_BITS;
    localparam int LEN_BITS        = 8;
    localparam int OUT_COLOR_BITS  = 16;

    localparam logic [COUNT_BITS-1:0] ESCAPE_HIGH = 3'd7;
    localparam logic [COUNT_BITS-1:0] COUNT_RAW   = 3'd0;

    // item operation codes
    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // result queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // run found by the decoder, waiting for its palette lookup
    typedef struct packed {
        logic                  valid;
        logic [LEN_BITS-1:0]   len;
        logic [INDEX_BITS-1:0] idx;
    } t_run_req;

    // finished run
    typedef struct packed {
        logic [OUT_COLOR_BITS-1:0] color;
        logic [LEN_BITS-1:0]       len;
        logic [INDEX_BITS-1:0]     idx;
    } t_run;

endpackage

// ----- rtl/prld_if.sv -----
// request and result channels of the palette run-length decoder
interface prld_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic        start_of_image;
    logic [7:0]  token_byte;
    logic [9:0]  palette_slot;
    logic [15:0] palette_color;

    modport source (output valid, operation, start_of_image, token_byte, palette_slot,
                    palette_color, input ready);
    modport sink   (input valid, operation, start_of_image, token_byte, palette_slot,
                    palette_color, output ready);
endinterface

interface prld_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] color;
    logic [7:0]  run_length;
    logic [9:0]  palette_index;

    modport source (output valid, color, run_length, palette_index, input ready);
    modport sink   (input valid, color, run_length, palette_index, output ready);
endinterface

// ----- rtl/prld_ram.sv -----
// generic single-port ram with registered read
module prld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and read-first registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/prld_decode.sv -----
// token parser: phase, high index and pending low index
module prld_decode (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_start,
    input  logic [7:0]              i_byte,
    output prld_pkg::t_run_req      o_req
);

    typedef enum logic [1:0] {
        PH_TOKEN  = 2'd0,
        PH_LOW    = 2'd1,
        PH_LENGTH = 2'd2
    } t_phase;

    t_phase r_phase, n_phase;
    logic [prld_pkg::INDEX_PART_BITS-1:0] r_high, n_high;
    logic [prld_pkg::INDEX_PART_BITS-1:0] r_pend, n_pend;

    logic [prld_pkg::COUNT_BITS-1:0]      w_cnt;
    logic [prld_pkg::INDEX_PART_BITS-1:0] w_part;
    logic [prld_pkg::INDEX_PART_BITS-1:0] w_high_eff;
    logic [prld_pkg::INDEX_PART_BITS-1:0] w_low;
    logic [prld_pkg::LEN_BITS-1:0]        w_len;
    logic                                 w_emit;
    logic [1:0]                           w_phase_eff;

    assign w_cnt  = i_byte[prld_pkg::COUNT_BITS-1:0];
    assign w_part = i_byte[7:prld_pkg::COUNT_BITS];

    // next decode state and run request
    always_comb begin
        w_phase_eff = i_start ? PH_TOKEN : r_phase;
        w_high_eff  = i_start ? '0 : r_high;
        n_phase     = PH_TOKEN;
        n_high      = w_high_eff;
        n_pend      = r_pend;
        w_low       = w_part;
        w_len       = prld_pkg::LEN_BITS'(w_cnt);
        w_emit      = 1'b0;
        unique case (w_phase_eff)
            PH_LENGTH: begin
                w_low  = r_pend;
                w_len  = i_byte;
                w_emit = (i_byte != '0);
            end
            default: begin
                if (w_phase_eff != PH_LOW && w_cnt == prld_pkg::ESCAPE_HIGH) begin
                    // high token: load sticky high part
                    n_high  = w_part;
                    n_phase = PH_LOW;
                end else if (w_cnt == prld_pkg::COUNT_RAW) begin
                    // raw length byte follows
                    n_pend  = w_part;
                    n_phase = PH_LENGTH;
                end else begin
                    w_emit = 1'b1;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN;
            r_high  <= '0;
            r_pend  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_pend  <= n_pend;
        end
    end

    assign o_req.valid = i_accept && w_emit;
    assign o_req.len   = w_len;
    assign o_req.idx   = {w_high_eff, w_low};

endmodule

// ----- rtl/prld_fifo.sv -----
// small result queue behind the palette read
module prld_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  prld_pkg::t_run                      i_data,
    input  logic                                i_pop,
    output prld_pkg::t_run                      o_head,
    output logic [prld_pkg::FIFO_CNT_W-1:0]     o_count
);

    prld_pkg::t_run r_mem [prld_pkg::FIFO_DEPTH];
    logic [prld_pkg::FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [prld_pkg::FIFO_CNT_W-1:0] r_count;
    logic                            w_pop;

    localparam logic [prld_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        prld_pkg::FIFO_PTR_W'(prld_pkg::FIFO_DEPTH - 1);

    assign w_pop = i_pop && (r_count != '0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ----- rtl/palette_run_length_decoder.sv -----
// palette run-length decoder top level
// path: a run leaves through the registered palette read and then the queue after the token that ends it
// throughput: one request per cycle; ready drops only while three runs are held
// back by the output, counting the palette read in flight and the three-entry queue
// reset: synchronous active-low clears phase, high index and queue; palette
// contents are kept and entries are defined only once written
module palette_run_length_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prld_in_if.sink    i_in,
    prld_out_if.source o_out
);

    logic                                    w_accept;
    logic                                    w_decode;
    logic                                    w_write;
    prld_pkg::t_run_req                      w_req;
    logic [prld_pkg::PAL_ADDR_W-1:0]         w_addr;
    logic [prld_pkg::COLOR_BITS-1:0]         w_rdata;
    logic [prld_pkg::FIFO_CNT_W-1:0]         w_count;
    logic [prld_pkg::FIFO_CNT_W:0]           w_occ;
    prld_pkg::t_run                          w_push_data;
    prld_pkg::t_run                          w_head;

    logic                                    r_s1_valid;
    logic                                    r_s1_hit;
    logic [prld_pkg::LEN_BITS-1:0]           r_s1_len;
    logic [prld_pkg::INDEX_BITS-1:0]         r_s1_idx;

    // request acceptance
    assign w_occ      = {1'b0, w_count} + (prld_pkg::FIFO_CNT_W + 1)'(r_s1_valid);
    assign i_in.ready = (w_occ < (prld_pkg::FIFO_CNT_W + 1)'(prld_pkg::FIFO_DEPTH));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_decode   = w_accept && (i_in.operation == prld_pkg::OP_DECODE);
    assign w_write    = w_accept && (i_in.operation == prld_pkg::OP_WRITE)
                        && (32'(i_in.palette_slot) < prld_pkg::PALETTE_DEPTH);

    prld_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_decode),
        .i_start  (i_in.start_of_image),
        .i_byte   (i_in.token_byte),
        .o_req    (w_req)
    );

    // palette port: write requests and run lookups share one address
    assign w_addr = (i_in.operation == prld_pkg::OP_WRITE)
                    ? i_in.palette_slot[prld_pkg::PAL_ADDR_W-1:0]
                    : w_req.idx[prld_pkg::PAL_ADDR_W-1:0];

    prld_ram #(
        .WIDTH (prld_pkg::COLOR_BITS),
        .DEPTH (prld_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_addr  (w_addr),
        .i_wdata (prld_pkg::COLOR_BITS'(i_in.palette_color)),
        .o_rdata (w_rdata)
    );

    // lookup stage, aligned with the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_req.valid;
        end
        r_s1_len <= w_req.len;
        r_s1_idx <= w_req.idx;
        r_s1_hit <= (32'(w_req.idx) < prld_pkg::PALETTE_DEPTH);
    end

    assign w_push_data.color = r_s1_hit ? prld_pkg::OUT_COLOR_BITS'(w_rdata) : '0;
    assign w_push_data.len   = r_s1_len;
    assign w_push_data.idx   = r_s1_idx;

    prld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (w_push_data),
        .i_pop   (o_out.ready),
        .o_head  (w_head),
        .o_count (w_count)
    );

    // result channel
    assign o_out.valid         = (w_count != '0);
    assign o_out.color         = w_head.color;
    assign o_out.run_length    = w_head.len;
    assign o_out.palette_index = w_head.idx;

endmodule

// ----- rtl/prld_checker.sv -----
// port-level checks of the palette run-length decoder and their binding
module prld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_color,
    input logic [7:0]  i_out_run_length,
    input logic [9:0]  i_out_palette_index
);

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_color)
        && $stable(i_out_run_length) && $stable(i_out_palette_index))
        else $error("stalled result changed");

    // zero-length runs never leave the block
    a_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_run_length != 8'd0)
        else $error("result with zero run length");

    // a result that appears on an empty output came from an accepted request, through the lookup stage and the queue
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a matching request");

endmodule

bind palette_run_length_decoder prld_checker u_prld_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_color         (o_out.color),
    .i_out_run_length    (o_out.run_length),
    .i_out_palette_index (o_out.palette_index)
);
